// ===== design/chp_pkg.sv =====
package chp_pkg;

	localparam logic [31:0] RESET_MASK = 32'h005F_837E;
	localparam logic [23:0] TS_ESCAPE  = 24'hFF_FFFF;
	localparam logic [16:0] ID_OFFSET  = 17'd64;
	localparam logic [3:0]  LEN_FMT0   = 4'd11;
	localparam logic [3:0]  LEN_FMT1   = 4'd7;
	localparam logic [3:0]  LEN_FMT2   = 4'd3;
	localparam logic [3:0]  LEN_EXT    = 4'd4;

	localparam logic [1:0] FMT_FULL  = 2'd0;
	localparam logic [1:0] FMT_DELTA = 2'd1;
	localparam logic [1:0] FMT_TIME  = 2'd2;
	localparam logic [1:0] FMT_NONE  = 2'd3;

	localparam logic [1:0] TSK_NONE  = 2'd0;
	localparam logic [1:0] TSK_ABS   = 2'd1;
	localparam logic [1:0] TSK_DELTA = 2'd2;

	typedef enum logic [4:0] {
		PH_BASIC1 = 5'b00001,
		PH_BASIC2 = 5'b00010,
		PH_BASIC3 = 5'b00100,
		PH_MSG    = 5'b01000,
		PH_EXT    = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [1:0]  fmt;
		logic [16:0] chunk_stream_id;
		logic [1:0]  timestamp_kind;
		logic [31:0] timestamp_value;
		logic        extended_used;
		logic        has_length_type;
		logic [23:0] message_len;
		logic [7:0]  msg_type;
		logic [31:0] msg_stream;
		logic [4:0]  header_bytes;
		logic        error;
	} result_t;

endpackage

// ===== design/chunk_header_parser.sv =====
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_stall  | byte_in
// out      | out_valid / out_stall| fmt .. error (one header per transaction)
// cfg      | cfg_valid / cfg_ready| valid_type_mask
//
// One byte per cycle while in_stall is low; when a header's last byte is taken,
// its result is written to the output register, or to the skid if that stays full.
// A two-entry output buffer (output register plus skid) lets input continue
// while a result waits; in_stall rises only when both entries hold results.
// arst_n clears the parser to the first basic header byte and the mask to its
// default; cfg_ready is always high.
module chunk_header_parser
	import chp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_in,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] valid_type_mask,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  fmt,
	output logic [16:0] chunk_stream_id,
	output logic [1:0]  timestamp_kind,
	output logic [31:0] timestamp_value,
	output logic        extended_used,
	output logic        has_length_type,
	output logic [23:0] message_len,
	output logic [7:0]  msg_type,
	output logic [31:0] msg_stream,
	output logic [4:0]  header_bytes,
	output logic        error
);

	phase_t      phase_q, phase_n;
	logic [3:0]  idx_q, idx_n;
	logic [4:0]  cnt_q, cnt_n;
	logic [1:0]  fmt_q, fmt_n;
	logic [16:0] sid_q, sid_n;
	logic [31:0] time_q, time_n;
	logic [23:0] len_q, len_n;
	logic [7:0]  type_q, type_n;
	logic [31:0] mstr_q, mstr_n;
	logic [31:0] mask_q;

	logic        emit, emit_err, emit_ext, basic_done, known;
	logic [3:0]  need;
	result_t     res_n, res_q, skid_q;
	logic        out_v_q, skid_v_q;
	logic        in_take, out_take;

	assign in_take   = in_valid && !skid_v_q;
	assign out_take  = out_v_q && !out_stall;
	assign in_stall  = skid_v_q;
	assign out_valid = out_v_q;
	assign cfg_ready = 1'b1;

	always_comb begin
		phase_n    = phase_q;
		idx_n      = idx_q;
		cnt_n      = cnt_q + 5'd1;
		fmt_n      = fmt_q;
		sid_n      = sid_q;
		time_n     = time_q;
		len_n      = len_q;
		type_n     = type_q;
		mstr_n     = mstr_q;
		emit       = 1'b0;
		emit_err   = 1'b0;
		emit_ext   = 1'b0;
		basic_done = 1'b0;
		known      = 1'b0;
		need       = LEN_FMT2;
		unique case (phase_q)
			PH_BASIC2: begin
				sid_n      = {9'd0, byte_in} + ID_OFFSET;
				basic_done = 1'b1;
			end
			PH_BASIC3: begin
				if (idx_q == 4'd0) begin
					sid_n = {9'd0, byte_in};
					idx_n = 4'd1;
				end else begin
					sid_n      = sid_q + {1'b0, byte_in, 8'd0} + ID_OFFSET;
					basic_done = 1'b1;
				end
			end
			PH_MSG: begin
				if (idx_q < 4'd3) begin
					time_n = {8'd0, time_q[15:0], byte_in};
				end else if (idx_q < 4'd6) begin
					len_n = {len_q[15:0], byte_in};
				end else if (idx_q == 4'd6) begin
					type_n = byte_in;
				end else begin
					case (idx_q)
						4'd7:    mstr_n[7:0]   = byte_in;
						4'd8:    mstr_n[15:8]  = byte_in;
						4'd9:    mstr_n[23:16] = byte_in;
						4'd10:   mstr_n[31:24] = byte_in;
						default: mstr_n = mstr_q;
					endcase
				end
				idx_n = idx_q + 4'd1;
				case (fmt_q)
					FMT_FULL:  need = LEN_FMT0;
					FMT_DELTA: need = LEN_FMT1;
					default:   need = LEN_FMT2;
				endcase
				known = (type_n[7:5] == 3'd0) && mask_q[type_n[4:0]];
				if (idx_n >= need) begin
					if (fmt_q == FMT_FULL || fmt_q == FMT_DELTA) begin
						if (!known) begin
							emit     = 1'b1;
							emit_err = 1'b1;
						end else if (time_n[23:0] == TS_ESCAPE) begin
							phase_n = PH_EXT;
							idx_n   = 4'd0;
							time_n  = 32'd0;
						end else begin
							emit = 1'b1;
						end
					end else begin
						emit = 1'b1;
					end
				end
			end
			PH_EXT: begin
				time_n = {time_q[23:0], byte_in};
				idx_n  = idx_q + 4'd1;
				if (idx_n >= LEN_EXT) begin
					emit     = 1'b1;
					emit_ext = 1'b1;
				end
			end
			default: begin
				cnt_n  = 5'd1;
				fmt_n  = byte_in[7:6];
				sid_n  = {11'd0, byte_in[5:0]};
				time_n = 32'd0;
				len_n  = 24'd0;
				type_n = 8'd0;
				mstr_n = 32'd0;
				idx_n  = 4'd0;
				if (byte_in[5:0] == 6'd0) begin
					phase_n = PH_BASIC2;
				end else if (byte_in[5:0] == 6'd1) begin
					phase_n = PH_BASIC3;
				end else begin
					basic_done = 1'b1;
				end
			end
		endcase
		if (basic_done) begin
			idx_n = 4'd0;
			if (fmt_n == FMT_NONE) begin
				emit = 1'b1;
			end else begin
				phase_n = PH_MSG;
			end
		end
		if (emit) begin
			phase_n = PH_BASIC1;
			idx_n   = 4'd0;
		end
	end

	always_comb begin
		res_n.fmt             = fmt_n;
		res_n.chunk_stream_id = sid_n;
		case (fmt_n)
			FMT_FULL: res_n.timestamp_kind = TSK_ABS;
			FMT_NONE: res_n.timestamp_kind = TSK_NONE;
			default:  res_n.timestamp_kind = TSK_DELTA;
		endcase
		res_n.timestamp_value = (fmt_n == FMT_NONE) ? 32'd0 : time_n;
		res_n.extended_used   = emit_ext;
		res_n.has_length_type = (fmt_n == FMT_FULL) || (fmt_n == FMT_DELTA);
		res_n.message_len     = res_n.has_length_type ? len_n : 24'd0;
		res_n.msg_type        = res_n.has_length_type ? type_n : 8'd0;
		res_n.msg_stream      = (fmt_n == FMT_FULL) ? mstr_n : 32'd0;
		res_n.header_bytes    = cnt_n;
		res_n.error           = emit_err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BASIC1;
			idx_q   <= 4'd0;
			cnt_q   <= 5'd0;
			fmt_q   <= 2'd0;
			sid_q   <= 17'd0;
			time_q  <= 32'd0;
			len_q   <= 24'd0;
			type_q  <= 8'd0;
			mstr_q  <= 32'd0;
		end else if (in_take) begin
			phase_q <= phase_n;
			idx_q   <= idx_n;
			cnt_q   <= cnt_n;
			fmt_q   <= fmt_n;
			sid_q   <= sid_n;
			time_q  <= time_n;
			len_q   <= len_n;
			type_q  <= type_n;
			mstr_q  <= mstr_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= RESET_MASK;
		end else if (cfg_valid && cfg_ready) begin
			mask_q <= valid_type_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_take) begin
				skid_v_q <= 1'b0;
			end
		end else if (in_take && emit) begin
			if (out_v_q && !out_take) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (out_take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_take) begin
				res_q <= skid_q;
			end
		end else if (in_take && emit) begin
			if (out_v_q && !out_take) begin
				skid_q <= res_n;
			end else begin
				res_q <= res_n;
			end
		end
	end

	assign fmt             = res_q.fmt;
	assign chunk_stream_id = res_q.chunk_stream_id;
	assign timestamp_kind  = res_q.timestamp_kind;
	assign timestamp_value = res_q.timestamp_value;
	assign extended_used   = res_q.extended_used;
	assign has_length_type = res_q.has_length_type;
	assign message_len     = res_q.message_len;
	assign msg_type        = res_q.msg_type;
	assign msg_stream      = res_q.msg_stream;
	assign header_bytes    = res_q.header_bytes;
	assign error           = res_q.error;

endmodule

// ===== design/chp_checker.sv =====
module chp_checker
	import chp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  fmt,
	input logic [1:0]  timestamp_kind,
	input logic        extended_used,
	input logic        has_length_type,
	input logic [4:0]  header_bytes,
	input logic        error
);

	// hold a stalled transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(header_bytes) && $stable(fmt))
		else $error("stalled output transaction changed");

	// input stalls only while the output register is full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output register");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((fmt == FMT_FULL && timestamp_kind == TSK_ABS)
			|| (fmt == FMT_NONE && timestamp_kind == TSK_NONE)
			|| ((fmt == FMT_DELTA || fmt == FMT_TIME) && timestamp_kind == TSK_DELTA))
			&& (has_length_type == (fmt == FMT_FULL || fmt == FMT_DELTA)))
		else $error("timestamp kind or length flag inconsistent with format");

	a_ext: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && extended_used |-> !error && has_length_type
			&& header_bytes >= 5'd9)
		else $error("extended timestamp on impossible header");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> header_bytes >= 5'd1 && header_bytes <= 5'd18)
		else $error("header byte count out of range");

endmodule

bind chunk_header_parser chp_checker u_chp_checker (.*);

// ===== bench/tb_chunk_header_parser.sv =====
`timescale 1ns / 100ps

module tb_chunk_header_parser;
	import chp_pkg::*;

	localparam int IDLE_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  byte_in = 8'd0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] valid_type_mask = 32'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  fmt;
	logic [16:0] chunk_stream_id;
	logic [1:0]  timestamp_kind;
	logic [31:0] timestamp_value;
	logic        extended_used;
	logic        has_length_type;
	logic [23:0] message_len;
	logic [7:0]  msg_type;
	logic [31:0] msg_stream;
	logic [4:0]  header_bytes;
	logic        error;

	logic [7:0] pending_bytes [$];
	result_t    headers_due [$];
	logic [31:0] gen_mask = RESET_MASK;

	// parser copy
	logic [31:0] type_mask = RESET_MASK;
	phase_t      p_phase = PH_BASIC1;
	logic [3:0]  p_idx = 4'd0;
	logic [4:0]  p_total = 5'd0;
	logic [1:0]  p_fmt = 2'd0;
	logic [16:0] p_csid = 17'd0;
	logic [31:0] p_time = 32'd0;
	logic [23:0] p_len = 24'd0;
	logic [7:0]  p_type = 8'd0;
	logic [31:0] p_mstr = 32'd0;

	int mismatches = 0;
	int headers_seen = 0;
	int idle_cycles = 0;
	int burst_left = 1;
	int gap_left = 0;
	int mode_left = 0;
	int stall_mode = 0;
	bit in_fire;
	result_t seen_header;
	result_t want_header;

	chunk_header_parser i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.byte_in         (byte_in),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.valid_type_mask (valid_type_mask),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.fmt             (fmt),
		.chunk_stream_id (chunk_stream_id),
		.timestamp_kind  (timestamp_kind),
		.timestamp_value (timestamp_value),
		.extended_used   (extended_used),
		.has_length_type (has_length_type),
		.message_len     (message_len),
		.msg_type        (msg_type),
		.msg_stream      (msg_stream),
		.header_bytes    (header_bytes),
		.error           (error)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < 40)
			$display("header %0d: %s got 0x%0h, want 0x%0h", headers_seen, what, got, want);
		mismatches++;
	endtask

	task emit_header(input bit ext, input bit err);
		result_t h;
		bit lt;
		lt = (p_fmt == FMT_FULL) || (p_fmt == FMT_DELTA);
		h.fmt = p_fmt;
		h.chunk_stream_id = p_csid;
		h.timestamp_kind = (p_fmt == FMT_FULL) ? TSK_ABS :
			((p_fmt == FMT_NONE) ? TSK_NONE : TSK_DELTA);
		h.timestamp_value = (p_fmt == FMT_NONE) ? 32'd0 : p_time;
		h.extended_used = ext;
		h.has_length_type = lt;
		h.message_len = lt ? p_len : 24'd0;
		h.msg_type = lt ? p_type : 8'd0;
		h.msg_stream = (p_fmt == FMT_FULL) ? p_mstr : 32'd0;
		h.header_bytes = p_total;
		h.error = err;
		headers_due.push_back(h);
		p_phase = PH_BASIC1;
		p_idx = 4'd0;
	endtask

	task after_basic;
		if (p_fmt == FMT_NONE) begin
			emit_header(1'b0, 1'b0);
		end else begin
			p_phase = PH_MSG;
			p_idx = 4'd0;
		end
	endtask

	task parse_byte(input logic [7:0] b);
		logic [3:0] need;
		bit known;
		p_total = p_total + 5'd1;
		case (p_phase)
			PH_BASIC2: begin
				p_csid = {9'd0, b} + ID_OFFSET;
				after_basic();
			end
			PH_BASIC3: begin
				if (p_idx == 4'd0) begin
					p_csid = {9'd0, b};
					p_idx = 4'd1;
				end else begin
					p_csid = p_csid + {1'b0, b, 8'd0} + ID_OFFSET;
					after_basic();
				end
			end
			PH_MSG: begin
				if (p_idx < 4'd3)
					p_time = {8'd0, p_time[15:0], b};
				else if (p_idx < 4'd6)
					p_len = {p_len[15:0], b};
				else if (p_idx == 4'd6)
					p_type = b;
				else if (p_idx < 4'd11)
					p_mstr = p_mstr | ({24'd0, b} << (8 * (p_idx - 4'd7)));
				p_idx = p_idx + 4'd1;
				need = (p_fmt == FMT_FULL) ? LEN_FMT0 :
					((p_fmt == FMT_DELTA) ? LEN_FMT1 : LEN_FMT2);
				if (p_idx >= need) begin
					if (p_fmt == FMT_FULL || p_fmt == FMT_DELTA) begin
						known = (p_type < 8'd32) && type_mask[p_type[4:0]];
						if (!known) begin
							emit_header(1'b0, 1'b1);
						end else if (p_time == {8'd0, TS_ESCAPE}) begin
							p_phase = PH_EXT;
							p_idx = 4'd0;
							p_time = 32'd0;
						end else begin
							emit_header(1'b0, 1'b0);
						end
					end else begin
						emit_header(1'b0, 1'b0);
					end
				end
			end
			PH_EXT: begin
				p_time = {p_time[23:0], b};
				p_idx = p_idx + 4'd1;
				if (p_idx >= LEN_EXT)
					emit_header(1'b1, 1'b0);
			end
			default: begin
				p_total = 5'd1;
				p_fmt = b[7:6];
				p_csid = {11'd0, b[5:0]};
				p_time = 32'd0;
				p_len = 24'd0;
				p_type = 8'd0;
				p_mstr = 32'd0;
				p_idx = 4'd0;
				if (b[5:0] == 6'd0)
					p_phase = PH_BASIC2;
				else if (b[5:0] == 6'd1)
					p_phase = PH_BASIC3;
				else
					after_basic();
			end
		endcase
	endtask

	function automatic logic [23:0] pick_field24();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 24'd0;
		if (r == 1)
			return 24'hFF_FFFF;
		return 24'($urandom);
	endfunction

	function automatic logic [7:0] pick_type(input logic [31:0] m);
		int r;
		logic [4:0] t;
		r = $urandom_range(0, 99);
		if (r < 15 || m == 32'd0)
			return 8'($urandom);
		if (r < 30)
			return 8'($urandom_range(0, 31));
		t = 5'($urandom);
		while (!m[t])
			t = 5'($urandom);
		return {3'd0, t};
	endfunction

	task automatic push_field(input logic [31:0] v, input int n);
		for (int i = n - 1; i >= 0; i--)
			pending_bytes.push_back(v[8 * i +: 8]);
	endtask

	task automatic gen_header(input logic [31:0] m);
		logic [1:0]  f;
		logic [23:0] ts;
		logic [7:0]  ty;
		logic [31:0] ms;
		int r;
		f = 2'($urandom);
		r = $urandom_range(0, 9);
		if (r < 6) begin
			pending_bytes.push_back({f, 6'($urandom_range(2, 63))});
		end else if (r < 8) begin
			pending_bytes.push_back({f, 6'd0});
			pending_bytes.push_back(8'($urandom));
		end else begin
			pending_bytes.push_back({f, 6'd1});
			pending_bytes.push_back(8'($urandom));
			pending_bytes.push_back(8'($urandom));
		end
		if (f == FMT_NONE)
			return;
		ts = ($urandom_range(0, 3) == 0) ? TS_ESCAPE : pick_field24();
		push_field({8'd0, ts}, 3);
		if (f == FMT_TIME)
			return;
		push_field({8'd0, pick_field24()}, 3);
		ty = pick_type(m);
		pending_bytes.push_back(ty);
		if (f == FMT_FULL) begin
			ms = $urandom;
			for (int i = 0; i < 4; i++)
				pending_bytes.push_back(ms[8 * i +: 8]);
		end
		if (ts == TS_ESCAPE && ty < 8'd32 && m[ty[4:0]])
			push_field($urandom, 4);
	endtask

	task automatic fill_random(input int count, input logic [31:0] m);
		int start;
		start = pending_bytes.size();
		while (pending_bytes.size() - start < count) begin
			if ($urandom_range(0, 99) < 8)
				repeat ($urandom_range(1, 4)) pending_bytes.push_back(8'($urandom));
			else
				gen_header(m);
		end
	endtask

	task drain;
		while (pending_bytes.size() != 0 || headers_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task write_mask(input logic [31:0] m);
		cfg_valid <= 1'b1;
		valid_type_mask <= m;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		gen_mask = m;
	endtask

	initial begin
		logic [7:0]  opening [];
		logic [31:0] mask_plan [5];
		opening = '{8'hFF, 8'hC2, 8'hC0, 8'hFF, 8'hC1, 8'hFF, 8'hFF,
			8'h85, 8'hFF, 8'hFF, 8'hFE,
			8'h43, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h14,
			8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'h3F, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF,
			8'h01, 8'h02, 8'h03, 8'h04,
			8'h82, 8'hFF, 8'hFF, 8'hFF};
		mask_plan = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, 32'h8000_0001, RESET_MASK};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (opening[i])
			pending_bytes.push_back(opening[i]);
		fill_random(300, gen_mask);
		foreach (mask_plan[i]) begin
			drain();
			@(posedge clk);
			write_mask(mask_plan[i]);
			@(negedge clk);
			fill_random(260, gen_mask);
		end
		drain();
		repeat (12) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				type_mask = valid_type_mask;
			in_fire = in_valid && !in_stall;
			if (in_fire) begin
				parse_byte(byte_in);
				void'(pending_bytes.pop_front());
			end
			if (!in_valid || in_fire) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_bytes.size() != 0) begin
					in_valid <= 1'b1;
					byte_in <= pending_bytes[0];
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 32);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= mode_left[3];
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen_header = {fmt, chunk_stream_id, timestamp_kind, timestamp_value,
				extended_used, has_length_type, message_len, msg_type, msg_stream,
				header_bytes, error};
			if (headers_due.size() == 0) begin
				report_mismatch("unexpected header, fmt", seen_header.fmt, 32'd0);
			end else begin
				want_header = headers_due.pop_front();
				if (seen_header.fmt !== want_header.fmt)
					report_mismatch("fmt", seen_header.fmt, want_header.fmt);
				if (seen_header.chunk_stream_id !== want_header.chunk_stream_id)
					report_mismatch("chunk_stream_id", seen_header.chunk_stream_id,
						want_header.chunk_stream_id);
				if (seen_header.timestamp_kind !== want_header.timestamp_kind)
					report_mismatch("timestamp_kind", seen_header.timestamp_kind,
						want_header.timestamp_kind);
				if (seen_header.timestamp_value !== want_header.timestamp_value)
					report_mismatch("timestamp_value", seen_header.timestamp_value,
						want_header.timestamp_value);
				if (seen_header.extended_used !== want_header.extended_used)
					report_mismatch("extended_used", seen_header.extended_used,
						want_header.extended_used);
				if (seen_header.has_length_type !== want_header.has_length_type)
					report_mismatch("has_length_type", seen_header.has_length_type,
						want_header.has_length_type);
				if (seen_header.message_len !== want_header.message_len)
					report_mismatch("message_len", seen_header.message_len,
						want_header.message_len);
				if (seen_header.msg_type !== want_header.msg_type)
					report_mismatch("msg_type", seen_header.msg_type, want_header.msg_type);
				if (seen_header.msg_stream !== want_header.msg_stream)
					report_mismatch("msg_stream", seen_header.msg_stream,
						want_header.msg_stream);
				if (seen_header.header_bytes !== want_header.header_bytes)
					report_mismatch("header_bytes", seen_header.header_bytes,
						want_header.header_bytes);
				if (seen_header.error !== want_header.error)
					report_mismatch("error", seen_header.error, want_header.error);
			end
			headers_seen++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
